/* src/rbfd_pkg.sv */
// ----------------------------------------------------------------------------
// rbfd_pkg: shared types and constants of the row box filter downscaler
// Fixed-point format, field widths, register indexes and the types that pass
// between the control, the channel lanes and the merge stage.
// ----------------------------------------------------------------------------
package rbfd_pkg;

	// Fixed point: 1.0 is 2^24
	localparam int FRAC_BITS = 24;
	localparam int WEIGHT_W  = 25;
	localparam logic [WEIGHT_W-1:0] FIXED_ONE = WEIGHT_W'(1 << FRAC_BITS);

	// Pixel layout: four 8-bit channels, blue in lane 0, alpha in lane 3
	localparam int CHAN_W  = 8;
	localparam int LANES   = 4;
	localparam int PIXEL_W = CHAN_W * LANES;
	localparam int SUM_W   = 32;

	// Field and register widths
	localparam int INDEX_W      = 12;
	localparam int CROP_START_W = 12;
	localparam int CROP_WIDTH_W = 13;
	localparam int CROP_SUM_W   = 14;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 25;

	localparam logic [CROP_WIDTH_W-1:0] CROP_WIDTH_RST = CROP_WIDTH_W'(4096);

	// Table depth default and output queue sizing (queue depth: power of two)
	localparam int MAX_OUT_WIDTH_DEF = 4096;
	localparam int OUTQ_DEPTH        = 8;
	localparam int OUTQ_CNT_W        = $clog2(OUTQ_DEPTH + 1);

	// Input commands
	typedef enum logic {
		CMD_TABLE_LOAD = 1'b0,
		CMD_PIXEL      = 1'b1
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FULL_PIXEL_WEIGHT = 2'd0,
		CFG_CROP_START        = 2'd1,
		CFG_CROP_WIDTH        = 2'd2
	} cfg_reg_t;

	// Per-item control carried from the decision stage to lanes and merge
	typedef struct packed {
		logic open_box;
		logic emit_close;
		logic last_close;
		logic emit_final;
		logic last_final;
	} rbfd_ctl_t;

	// One queued result
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               last;
	} rbfd_item_t;

endpackage

/* src/row_box_filter_downscale.sv */
// ----------------------------------------------------------------------------
// row_box_filter_downscale: horizontal fractional box-filter downscaler
// ARGB8888 rows, weights in fixed point with 1.0 = 2^24, four channel lanes
// merged into one output queue.
// ----------------------------------------------------------------------------
// The block takes one item per clock while it does not stall: a coverage
// table load or a source pixel. Box decisions (weight left, box open, output
// position) settle in the cycle an item is accepted, the four channel lanes
// multiply in that same cycle and accumulate in the next, which also writes
// the results into the output queue. A pixel that closes one box and opens
// another that closes at once yields two results; the output drains one
// result per cycle while out_stall is low, and the input stalls whenever the
// eight-entry output queue could not take two results for the item in
// flight and two for the offered one. The coverage table is a RAM read one
// item ahead at the output position; it needs no clearing after reset, but
// every entry must be loaded before a row reaches it.
// ----------------------------------------------------------------------------
module row_box_filter_downscale #(
	parameter int MAX_OUT_WIDTH = rbfd_pkg::MAX_OUT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [rbfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic [rbfd_pkg::INDEX_W-1:0]      table_index,
	input  logic [rbfd_pkg::WEIGHT_W-1:0]     table_value,
	input  logic [rbfd_pkg::PIXEL_W-1:0]      pixel_in,
	input  logic                              row_end,
	// result items
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rbfd_pkg::PIXEL_W-1:0]      pixel_out,
	output logic                              last_of_row
);
	import rbfd_pkg::*;

	localparam int ADDR_W = $clog2(MAX_OUT_WIDTH);
	localparam int POS_W  = $clog2(MAX_OUT_WIDTH + 1);
	localparam int CMP_W  = (POS_W > CROP_SUM_W) ? POS_W : CROP_SUM_W;
	localparam int IDX_CMP_W = (INDEX_W > POS_W) ? INDEX_W + 1 : POS_W + 1;

	// Configuration registers
	logic [WEIGHT_W-1:0]     full_pixel_weight_q;
	logic [CROP_START_W-1:0] crop_start_q;
	logic [CROP_WIDTH_W-1:0] crop_width_q;

	// Row state
	logic [POS_W-1:0]        pos_q;
	logic [WEIGHT_W-1:0]     weight_left_q;
	logic                    box_open_q;

	// Table read bypass
	logic                    byp_q;
	logic [WEIGHT_W-1:0]     byp_data_q;

	// Decision stage to lanes
	logic                    acc_valid_s1;
	rbfd_ctl_t               ctl_s1;

	logic                    in_acc;
	logic                    px_acc;
	logic                    ld_acc;
	logic                    idx_ok;
	logic [ADDR_W-1:0]       wr_addr;
	logic [ADDR_W-1:0]       rd_addr;
	logic [WEIGHT_W-1:0]     ram_rdata;
	logic [WEIGHT_W-1:0]     cov;
	logic [CROP_SUM_W-1:0]   crop_end;
	logic [CMP_W-1:0]        lim_full;
	logic [POS_W-1:0]        lim;
	logic [POS_W-1:0]        pos_open;
	logic [POS_W-1:0]        pos_d;
	logic [WEIGHT_W-1:0]     pc;
	logic                    cont;
	logic [WEIGHT_W-1:0]     w_old;
	logic [WEIGHT_W-1:0]     wl_open;
	logic [WEIGHT_W-1:0]     wl_after;
	logic                    open_now;
	logic                    box_after;
	logic                    close_now;
	logic                    close_final;
	rbfd_ctl_t               ctl_d;
	logic [WEIGHT_W-1:0]     weight_left_d;
	logic                    box_open_d;
	logic [OUTQ_CNT_W-1:0]   q_count;
	logic [OUTQ_CNT_W:0]     q_need;
	logic [CHAN_W-1:0]       res_close [LANES];
	logic [CHAN_W-1:0]       res_final [LANES];

	// Input handshake; hold off while the queue could overflow
	assign q_need   = {1'b0, q_count} + ((OUTQ_CNT_W + 1)'(acc_valid_s1) << 1);
	assign in_stall = (q_need > (OUTQ_CNT_W + 1)'(OUTQ_DEPTH - 2));
	assign in_acc   = in_valid && !in_stall;
	assign px_acc   = in_acc && (command == CMD_PIXEL);
	assign ld_acc   = in_acc && (command == CMD_TABLE_LOAD);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_pixel_weight_q <= FIXED_ONE;
			crop_start_q        <= '0;
			crop_width_q        <= CROP_WIDTH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FULL_PIXEL_WEIGHT: full_pixel_weight_q <= cfg_data[WEIGHT_W-1:0];
				CFG_CROP_START:        crop_start_q <= cfg_data[CROP_START_W-1:0];
				CFG_CROP_WIDTH:        crop_width_q <= cfg_data[CROP_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Output limit: crop end, capped at the table size
	assign crop_end = CROP_SUM_W'(crop_start_q) + CROP_SUM_W'(crop_width_q);
	assign lim_full = (CMP_W'(crop_end) > CMP_W'(MAX_OUT_WIDTH)) ?
		CMP_W'(MAX_OUT_WIDTH) : CMP_W'(crop_end);
	assign lim      = lim_full[POS_W-1:0];

	// Box decisions for the pixel at the input
	always_comb begin
		pc        = full_pixel_weight_q;
		cont      = box_open_q && (weight_left_q >= pc);
		w_old     = cont ? pc : weight_left_q;
		close_now = box_open_q && !cont;
		open_now  = !cont && (pos_q < lim);
		pos_open  = pos_q + POS_W'(open_now);
		wl_open   = (cov >= FIXED_ONE) ? '0 : FIXED_ONE - cov;
		if (open_now) begin
			wl_after = wl_open;
		end else if (cont) begin
			wl_after = weight_left_q - pc;
		end else begin
			wl_after = '0;
		end
		box_after   = cont || open_now;
		close_final = box_after && (((wl_after == '0) && (pc != '0)) || row_end);

		ctl_d.open_box   = open_now;
		ctl_d.emit_close = close_now && (CMP_W'(pos_q) > CMP_W'(crop_start_q));
		ctl_d.last_close = (pos_q >= lim);
		ctl_d.emit_final = close_final && (CMP_W'(pos_open) > CMP_W'(crop_start_q));
		ctl_d.last_final = row_end || (pos_open >= lim);

		// Next row state; row end returns to the start of a row
		pos_d         = pos_q;
		weight_left_d = weight_left_q;
		box_open_d    = box_open_q;
		if (px_acc) begin
			if (row_end) begin
				pos_d         = '0;
				weight_left_d = '0;
				box_open_d    = 1'b0;
			end else begin
				pos_d         = pos_open;
				weight_left_d = close_final ? '0 : wl_after;
				box_open_d    = box_after && !close_final;
			end
		end
	end

	// Row state and decision stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			weight_left_q <= '0;
			box_open_q    <= 1'b0;
			acc_valid_s1  <= 1'b0;
			ctl_s1        <= '0;
			byp_q         <= 1'b0;
		end else begin
			pos_q         <= pos_d;
			weight_left_q <= weight_left_d;
			box_open_q    <= box_open_d;
			acc_valid_s1  <= px_acc;
			if (px_acc) begin
				ctl_s1 <= ctl_d;
			end
			byp_q <= ld_acc && idx_ok && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_acc) begin
			byp_data_q <= table_value;
		end
	end

	// Coverage table, read ahead at the next output position
	assign idx_ok  = (IDX_CMP_W'(table_index) < IDX_CMP_W'(MAX_OUT_WIDTH));
	assign wr_addr = ADDR_W'(table_index);
	assign rd_addr = ADDR_W'(pos_d);
	assign cov     = byp_q ? byp_data_q : ram_rdata;

	rbfd_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (MAX_OUT_WIDTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ld_acc && idx_ok),
		.wr_addr (wr_addr),
		.wr_data (table_value),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	// Channel lanes
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		rbfd_lane u_lane (
			.clk       (clk),
			.load      (px_acc),
			.chan      (pixel_in[CHAN_W*i +: CHAN_W]),
			.w_old     (w_old),
			.cov       (cov),
			.acc_en    (acc_valid_s1),
			.open_box  (ctl_s1.open_box),
			.res_close (res_close[i]),
			.res_final (res_final[i])
		);
	end

	// Merge lanes and queue results
	rbfd_merge #(
		.DEPTH (OUTQ_DEPTH)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc_en      (acc_valid_s1),
		.ctl         (ctl_s1),
		.res_close   (res_close),
		.res_final   (res_final),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_out   (pixel_out),
		.last_of_row (last_of_row),
		.count       (q_count)
	);

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(px_acc && row_end) |=> ((pos_q == '0) && !box_open_q && (weight_left_q == '0)))
		else $error("row state not cleared after row end");

	a_open_has_pos: assert property (@(posedge clk) disable iff (!arst_n)
		box_open_q |-> ((pos_q != '0) && (pos_q <= POS_W'(MAX_OUT_WIDTH))))
		else $error("open box without a matching output position");

	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		weight_left_q <= FIXED_ONE)
		else $error("weight left exceeds one");

endmodule

/* src/rbfd_ram.sv */
// ----------------------------------------------------------------------------
// rbfd_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rbfd_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* src/rbfd_lane.sv */
// ----------------------------------------------------------------------------
// rbfd_lane: one channel lane of the box filter
// Weights one 8-bit channel of the item, then folds the products into the
// running box sum and hands out the averaged byte of each closed box.
// ----------------------------------------------------------------------------
module rbfd_lane (
	input  logic                          clk,
	input  logic                          load,
	input  logic [rbfd_pkg::CHAN_W-1:0]   chan,
	input  logic [rbfd_pkg::WEIGHT_W-1:0] w_old,
	input  logic [rbfd_pkg::WEIGHT_W-1:0] cov,
	input  logic                          acc_en,
	input  logic                          open_box,
	output logic [rbfd_pkg::CHAN_W-1:0]   res_close,
	output logic [rbfd_pkg::CHAN_W-1:0]   res_final
);
	import rbfd_pkg::*;

	localparam int MUL_W = CHAN_W + WEIGHT_W;

	logic [MUL_W-1:0] mult_old;
	logic [MUL_W-1:0] mult_new;
	logic [SUM_W-1:0] prod_old_s1;
	logic [SUM_W-1:0] prod_new_s1;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] acc_old;
	logic [SUM_W-1:0] sum_new;

	// Weight the channel for the running box and for a box opened here
	assign mult_old = MUL_W'(chan) * MUL_W'(w_old);
	assign mult_new = MUL_W'(chan) * MUL_W'(cov);

	always_ff @(posedge clk) begin
		if (load) begin
			prod_old_s1 <= mult_old[SUM_W-1:0];
			prod_new_s1 <= mult_new[SUM_W-1:0];
		end
	end

	// Accumulate; a newly opened box restarts from its own product
	assign acc_old = sum_q + prod_old_s1;
	assign sum_new = open_box ? prod_new_s1 : acc_old;

	always_ff @(posedge clk) begin
		if (acc_en) begin
			sum_q <= sum_new;
		end
	end

	// Drop the fraction bits
	assign res_close = acc_old[FRAC_BITS +: CHAN_W];
	assign res_final = sum_new[FRAC_BITS +: CHAN_W];

endmodule

/* src/rbfd_merge.sv */
// ----------------------------------------------------------------------------
// rbfd_merge: lane merge and output queue
// Joins the four lane bytes into pixels and queues up to two results per
// item, draining one result per cycle to the output channel unless it stalls.
// ----------------------------------------------------------------------------
module rbfd_merge #(
	parameter int DEPTH = rbfd_pkg::OUTQ_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               acc_en,
	input  rbfd_pkg::rbfd_ctl_t                ctl,
	input  logic [rbfd_pkg::CHAN_W-1:0]        res_close [rbfd_pkg::LANES],
	input  logic [rbfd_pkg::CHAN_W-1:0]        res_final [rbfd_pkg::LANES],
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rbfd_pkg::PIXEL_W-1:0]       pixel_out,
	output logic                               last_of_row,
	output logic [$clog2(DEPTH+1)-1:0]         count
);
	import rbfd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rbfd_item_t        queue_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	rbfd_item_t        item_close;
	rbfd_item_t        item_final;
	rbfd_item_t        item_a;
	logic              push_close;
	logic              push_final;
	logic              push_any;
	logic              push_two;
	logic              pop;
	logic [CNT_W-1:0]  n_push;

	// Merge lane bytes into pixels
	always_comb begin
		item_close.last = ctl.last_close;
		item_final.last = ctl.last_final;
		for (int i = 0; i < LANES; i++) begin
			item_close.pixel[CHAN_W*i +: CHAN_W] = res_close[i];
			item_final.pixel[CHAN_W*i +: CHAN_W] = res_final[i];
		end
	end

	assign push_close = acc_en && ctl.emit_close;
	assign push_final = acc_en && ctl.emit_final;
	assign push_any   = push_close || push_final;
	assign push_two   = push_close && push_final;
	assign item_a     = push_close ? item_close : item_final;
	assign n_push     = CNT_W'(push_close) + CNT_W'(push_final);
	assign pop        = out_valid && !out_stall;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push_any) begin
			queue_q[wr_ptr_q] <= item_a;
		end
		if (push_two) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= item_final;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

	assign out_valid   = (count_q != '0);
	assign pixel_out   = queue_q[rd_ptr_q].pixel;
	assign last_of_row = queue_q[rd_ptr_q].last;
	assign count       = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("output queue holds more results than its depth");

	a_room_for_two: assert property (@(posedge clk) disable iff (!arst_n)
		push_two |-> (count_q <= CNT_W'(DEPTH - 2)))
		else $error("two results pushed without room in the output queue");

endmodule

/* tb/sv/row_box_filter_downscale_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// row_box_filter_downscale_check: result predictor and comparator
// Watches the configuration port and both item channels of the downscaler,
// tracks the box state and the start-weight table, and compares every
// accepted output pixel with the oldest predicted one.
// ----------------------------------------------------------------------------
module row_box_filter_downscale_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rbfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbfd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            command,
	input  logic [rbfd_pkg::INDEX_W-1:0]    table_index,
	input  logic [rbfd_pkg::WEIGHT_W-1:0]   table_value,
	input  logic [rbfd_pkg::PIXEL_W-1:0]    pixel_in,
	input  logic                            row_end,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [rbfd_pkg::PIXEL_W-1:0]    pixel_out,
	input  logic                            last_of_row,
	output int                              mismatches,
	output int                              outstanding
);
	import rbfd_pkg::*;

	// Register copies
	logic [WEIGHT_W-1:0]     pixel_weight = FIXED_ONE;
	logic [CROP_START_W-1:0] crop_start   = '0;
	logic [CROP_WIDTH_W-1:0] crop_width   = CROP_WIDTH_RST;

	// Row state and coverage table
	logic [WEIGHT_W-1:0]     start_weight [MAX_OUT_WIDTH_DEF];
	logic [CROP_WIDTH_W-1:0] boxes_opened = '0;
	logic [WEIGHT_W-1:0]     weight_left  = '0;
	logic                    box_live     = 1'b0;
	logic [SUM_W-1:0]        chan_sum [LANES] = '{default: '0};

	rbfd_item_t expected_pixels [$];
	rbfd_item_t want;

	function automatic void clear_sums();
		for (int l = 0; l < LANES; l++)
			chan_sum[l] = '0;
	endfunction

	function automatic void clear_row();
		boxes_opened = '0;
		weight_left  = '0;
		box_live     = 1'b0;
		clear_sums();
	endfunction

	// Multiply each channel by the weight, wrap at the sum width
	function automatic void add_pixel(logic [PIXEL_W-1:0] pix, logic [WEIGHT_W-1:0] w);
		for (int l = 0; l < LANES; l++)
			chan_sum[l] += SUM_W'(pix[l*CHAN_W +: CHAN_W]) * SUM_W'(w);
	endfunction

	function automatic void open_box(logic [PIXEL_W-1:0] pix);
		logic [WEIGHT_W-1:0] cov;
		cov = start_weight[boxes_opened[INDEX_W-1:0]];
		clear_sums();
		add_pixel(pix, cov);
		weight_left  = (cov >= FIXED_ONE) ? '0 : FIXED_ONE - cov;
		boxes_opened = boxes_opened + 1'b1;
		box_live     = 1'b1;
	endfunction

	// Emit the box unless it lies before the crop start, then drop it
	function automatic void close_box(logic last);
		rbfd_item_t res;
		if (CROP_SUM_W'(boxes_opened) > CROP_SUM_W'(crop_start)) begin
			for (int l = 0; l < LANES; l++)
				res.pixel[l*CHAN_W +: CHAN_W] = chan_sum[l][SUM_W-1 -: CHAN_W];
			res.last = last;
			expected_pixels.push_back(res);
		end
		box_live    = 1'b0;
		weight_left = '0;
		clear_sums();
	endfunction

	function automatic void take_pixel(logic [PIXEL_W-1:0] pix, logic re);
		logic [WEIGHT_W-1:0]   pc;
		logic [CROP_SUM_W-1:0] lim;
		logic                  used;
		pc   = pixel_weight;
		lim  = CROP_SUM_W'(crop_start) + CROP_SUM_W'(crop_width);
		used = 1'b0;
		if (lim > CROP_SUM_W'(MAX_OUT_WIDTH_DEF))
			lim = CROP_SUM_W'(MAX_OUT_WIDTH_DEF);
		// Feed the open box a full pixel, or its leftover and close it
		if (box_live) begin
			if (weight_left >= pc) begin
				add_pixel(pix, pc);
				weight_left = weight_left - pc;
				used = 1'b1;
			end else begin
				add_pixel(pix, weight_left);
				close_box(CROP_SUM_W'(boxes_opened) >= lim);
			end
		end
		if (!used && !box_live && CROP_SUM_W'(boxes_opened) < lim)
			open_box(pix);
		if (box_live && ((weight_left == '0 && pc != '0) || re))
			close_box(re || CROP_SUM_W'(boxes_opened) >= lim);
		if (re)
			clear_row();
	endfunction

	// Track registers and input items, compare output items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_weight = FIXED_ONE;
			crop_start   = '0;
			crop_width   = CROP_WIDTH_RST;
			clear_row();
			expected_pixels.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_FULL_PIXEL_WEIGHT: pixel_weight = cfg_data[WEIGHT_W-1:0];
					CFG_CROP_START:        crop_start   = cfg_data[CROP_START_W-1:0];
					CFG_CROP_WIDTH:        crop_width   = cfg_data[CROP_WIDTH_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (command == CMD_TABLE_LOAD)
					start_weight[table_index] = table_value;
				else
					take_pixel(pixel_in, row_end);
			end
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected item pixel_out %h last_of_row %b",
						$time, pixel_out, last_of_row);
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_out !== want.pixel) begin
						mismatches++;
						$display("%0t: pixel_out expected %h got %h",
							$time, want.pixel, pixel_out);
					end
					if (last_of_row !== want.last) begin
						mismatches++;
						$display("%0t: last_of_row expected %b got %b",
							$time, want.last, last_of_row);
					end
				end
			end
			outstanding <= expected_pixels.size();
		end
	end

endmodule

/* tb/sv/row_box_filter_downscale_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// row_box_filter_downscale_tb: stimulus and verdict for the downscaler
// Loads the reachable coverage table entries, runs directed rows, then crop
// and weight settings from the extremes to random ones with random rows,
// random input gaps and output stalls, and reports the outcome of the checker.
// ----------------------------------------------------------------------------
module row_box_filter_downscale_tb;
	import rbfd_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 80;
	localparam int REACH_ENTRIES = 32;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = CFG_FULL_PIXEL_WEIGHT;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  command     = CMD_PIXEL;
	logic [INDEX_W-1:0]    table_index = '0;
	logic [WEIGHT_W-1:0]   table_value = '0;
	logic [PIXEL_W-1:0]    pixel_in    = '0;
	logic                  row_end     = 1'b0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [PIXEL_W-1:0]    pixel_out;
	logic                  last_of_row;
	int                    mismatches;
	int                    outstanding;

	// Output side pacing
	logic idling        = 1'b1;
	int   hold_requests = 0;
	int   holds_done    = 0;
	int   hold_left     = 0;
	int   stall_left    = 0;
	int   quiet_left    = 0;
	int   send_quiet    = 0;
	int   cycle_count   = 0;

	row_box_filter_downscale dut (.*);
	row_box_filter_downscale_check chk (.*);

	always #4 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Stall the output: long holds on request, random bursts, quiet stretches
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			holds_done <= hold_requests;
			hold_left  <= HOLD_CYCLES;
			out_stall  <= 1'b1;
		end else if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (quiet_left != 0) begin
			out_stall  <= 1'b0;
			quiet_left <= quiet_left - 1;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 15) == 0)
				quiet_left <= $urandom_range(10, 40);
		end
	end

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return FIXED_ONE;
			2: return WEIGHT_W'($urandom_range(32'(FIXED_ONE) + 1, (1 << WEIGHT_W) - 1));
			default: return WEIGHT_W'($urandom_range(1, 32'(FIXED_ONE) - 1));
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] rand_pixel_weight();
		case ($urandom_range(0, 7))
			0: return FIXED_ONE;
			1: return WEIGHT_W'($urandom);
			default: return WEIGHT_W'(32'(FIXED_ONE) / $urandom_range(2, 6) + $urandom_range(0, 3));
		endcase
	endfunction

	function automatic logic [PIXEL_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Offer one item, with an optional gap first, and hold it until taken
	task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
			input logic [WEIGHT_W-1:0] val, input logic [PIXEL_W-1:0] pix, input logic re);
		if (send_quiet != 0) begin
			send_quiet--;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end else if ($urandom_range(0, 19) == 0) begin
			send_quiet = $urandom_range(10, 30);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		table_index <= idx;
		table_value <= val;
		pixel_in    <= pix;
		row_end     <= re;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
		send_item(CMD_TABLE_LOAD, idx, val, $urandom, 1'($urandom));
	endtask

	task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic re);
		send_item(CMD_PIXEL, INDEX_W'($urandom), WEIGHT_W'($urandom), pix, re);
	endtask

	// One row of pixels with table loads mixed in
	task automatic send_row(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 6) == 0)
				load_entry(($urandom_range(0, 3) == 0) ? INDEX_W'($urandom) :
					INDEX_W'($urandom_range(0, REACH_ENTRIES - 1)), rand_weight());
			send_pixel(rand_pixel(), i == len - 1);
		end
	endtask

	// Stop offering and wait until every predicted item has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [WEIGHT_W-1:0] fpw,
			input logic [CROP_START_W-1:0] cs, input logic [CROP_WIDTH_W-1:0] cw);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_FULL_PIXEL_WEIGHT;
		cfg_data  <= CFG_DATA_W'(fpw);
		@(posedge clk);
		cfg_index <= CFG_CROP_START;
		cfg_data  <= CFG_DATA_W'(cs);
		@(posedge clk);
		cfg_index <= CFG_CROP_WIDTH;
		cfg_data  <= CFG_DATA_W'(cw);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Reconfigure while idle, then send rows with a drain halfway
	task automatic run_phase(input logic [WEIGHT_W-1:0] fpw,
			input logic [CROP_START_W-1:0] cs, input logic [CROP_WIDTH_W-1:0] cw,
			input int rows, input int min_len, input int max_len, input logic hold_output);
		settle();
		set_config(fpw, cs, cw);
		if (hold_output)
			hold_requests <= hold_requests + 1;
		for (int r = 0; r < rows; r++) begin
			if (r == rows / 2)
				settle();
			send_row($urandom_range(min_len, max_len));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every entry that a row of up to 24 pixels can reach
		for (int i = 0; i < REACH_ENTRIES; i++)
			load_entry(INDEX_W'(i), rand_weight());

		// Zero, one, above-one and half start weights, highest index
		send_item(CMD_TABLE_LOAD, INDEX_W'(0), '0, '0, 1'b0);
		send_item(CMD_TABLE_LOAD, INDEX_W'(1), FIXED_ONE, '0, 1'b0);
		send_item(CMD_TABLE_LOAD, INDEX_W'(2), '1, '1, 1'b1);
		send_item(CMD_TABLE_LOAD, INDEX_W'(3), FIXED_ONE >> 1, '0, 1'b0);
		send_item(CMD_TABLE_LOAD, '1, WEIGHT_W'(32'(FIXED_ONE) / 3), '1, 1'b1);
		// Zero-weight box, full box, wrapping sums, leftover plus row end
		send_pixel('1, 1'b0);
		send_pixel('0, 1'b0);
		send_pixel('1, 1'b0);
		send_pixel(32'h80FF017F, 1'b0);
		send_pixel('1, 1'b0);
		send_pixel('1, 1'b1);
		// Single-pixel rows
		send_pixel(32'h7F00FF80, 1'b1);
		send_pixel('1, 1'b1);

		// Register extremes and corner settings
		run_phase(WEIGHT_W'(32'(FIXED_ONE) / 3), 2, 5, 2, 1, 24, 1'b0);
		run_phase(WEIGHT_W'(1), 0, 1, 2, 1, 24, 1'b0);
		run_phase('1, 0, '1, 2, 1, 24, 1'b0);
		run_phase('0, 1, 3, 2, 1, 24, 1'b0);
		run_phase(FIXED_ONE, 3, 0, 2, 1, 24, 1'b0);
		// Back up the output while a full-weight row keeps coming
		run_phase(FIXED_ONE, 0, CROP_WIDTH_RST, 1, 20, 20, 1'b1);

		// Random settings
		for (int p = 0; p < 4; p++)
			run_phase(rand_pixel_weight(), CROP_START_W'($urandom_range(0, 6)),
				($urandom_range(0, 5) == 0) ? CROP_WIDTH_RST :
				CROP_WIDTH_W'($urandom_range(0, 12)), 3, 1, 24, 1'b0);

		// Finish at full rate on both sides
		idling <= 1'b0;
		run_phase(rand_pixel_weight(), CROP_START_W'($urandom_range(0, 3)),
			CROP_WIDTH_W'($urandom_range(1, 12)), 3, 1, 24, 1'b0);
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
